### src/fpiq_pkg.sv
// Package for the front panel input qualifier.
// Holds the request and result structs, register state, register indexes and reset values.
// No dependencies.
`default_nettype none

package fpiq_pkg;

  localparam int STEP_KEYS  = 12;
  localparam int KEY_NUM_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECT_DEBOUNCE = 3'd0,
    CFG_MATRIX_DEBOUNCE = 3'd1,
    CFG_LONG_PRESS      = 3'd2,
    CFG_ARM_RELEASE     = 3'd3,
    CFG_STARTUP_QUIET   = 3'd4,
    CFG_BUTTON_POLL     = 3'd5,
    CFG_MATRIX_SCAN     = 3'd6
  } cfg_idx_t;

  localparam logic [7:0]  DIRECT_DEBOUNCE_RST = 8'd15;
  localparam logic [7:0]  MATRIX_DEBOUNCE_RST = 8'd12;
  localparam logic [15:0] LONG_PRESS_RST      = 16'd350;
  localparam logic [9:0]  ARM_RELEASE_RST     = 10'd60;
  localparam logic [9:0]  STARTUP_QUIET_RST   = 10'd120;
  localparam logic [7:0]  BUTTON_POLL_RST     = 8'd4;
  localparam logic [7:0]  MATRIX_SCAN_RST     = 8'd10;

  localparam logic signed [15:0] STEP_CLAMP = 16'sd127;

  typedef struct packed {
    logic [31:0]          now_ms;
    logic [15:0]          enc_count;
    logic                 enc_button_level;
    logic [2:0]           panel_buttons_n;
    logic [STEP_KEYS-1:0] key_matrix;
  } in_t;

  typedef struct packed {
    logic signed [7:0]    encoder_steps;
    logic                 enc_press;
    logic                 enc_short;
    logic                 enc_long;
    logic                 play_event;
    logic                 shift_play_event;
    logic                 rec_event;
    logic                 shift_rec_event;
    logic                 shift_tap;
    logic [KEY_NUM_W-1:0] step_key;
    logic [KEY_NUM_W-1:0] shift_step_key;
    logic                 shift_level;
  } out_t;

  typedef struct packed {
    logic [7:0]  btn_settle_ms;
    logic [7:0]  key_settle_ms;
    logic [15:0] long_press_ms;
    logic [9:0]  arm_release_ms;
    logic [9:0]  startup_quiet_ms;
    logic [7:0]  button_poll_ms;
    logic [7:0]  matrix_scan_ms;
  } cfg_t;

  typedef struct packed {
    logic                 started;
    logic [15:0]          last_count;
    logic                 enc_prev_level;
    logic                 enc_is_down;
    logic                 long_fired;
    logic [31:0]          enc_down_time;
    logic [31:0]          last_button_poll;
    logic [31:0]          last_key_scan;
    logic [31:0]          quiet_until;
    logic [2:0]           button_candidate;
    logic [31:0]          button_candidate_time;
    logic [2:0]           button_stable;
    logic [2:0]           button_stable_prev;
    logic                 armed;
    logic [31:0]          released_since;
    logic                 shift_down;
    logic                 shift_used;
    logic [STEP_KEYS-1:0] key_candidate;
    logic [31:0]          key_candidate_time;
    logic [STEP_KEYS-1:0] key_stable;
  } st_t;

endpackage

`default_nettype wire

### src/front_panel_input_qualifier.sv
// Top level of the front panel input qualifier: request, result and register ports.
// Instantiates fpiq_eval and holds panel state and settings. Depends on fpiq_pkg.
`default_nettype none

// Each request is one poll of the panel (time stamp, encoder counter, encoder
// button, play/rec/shift buttons, step key mask) and yields exactly one result.
// A request is taken every cycle unless a stalled result register holds the
// flow; it waits in the input register while the single-pass evaluation
// updates the panel state, and its result is then loaded into the result
// register, where it is held until taken. The first poll after reset only
// captures the initial levels and returns an all-zero result. Registers are
// written through cfg_wdata (low bits used), cfg_we and cfg_idx; the user must
// write them only while no poll is in flight, which the block does not enforce.
// Indexes beyond the last register are dropped.
module front_panel_input_qualifier
  import fpiq_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire in_t             in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output out_t                 out_data,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_idx,
  input  wire [CFG_DATA_W-1:0] cfg_wdata
);

  logic s1_vld_r;
  in_t  s1_data_r;
  logic out_vld_r;
  out_t out_data_r;
  st_t  st_r;
  st_t  st_nxt;
  st_t  st_rst;
  out_t res;
  cfg_t cfg_r;
  logic adv_out;
  logic fire;

  assign adv_out   = !out_vld_r || out_ready;
  assign fire      = s1_vld_r && adv_out;
  assign in_ready  = !s1_vld_r || adv_out;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  always_comb begin
    st_rst                = '0;
    st_rst.enc_prev_level = 1'b1;
  end

  fpiq_eval u_eval (
    .item   (s1_data_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) s1_vld_r <= in_valid;
      if (adv_out) out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_data_r <= in_data;
    if (fire) out_data_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_rst;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.btn_settle_ms    <= DIRECT_DEBOUNCE_RST;
      cfg_r.key_settle_ms    <= MATRIX_DEBOUNCE_RST;
      cfg_r.long_press_ms    <= LONG_PRESS_RST;
      cfg_r.arm_release_ms   <= ARM_RELEASE_RST;
      cfg_r.startup_quiet_ms <= STARTUP_QUIET_RST;
      cfg_r.button_poll_ms   <= BUTTON_POLL_RST;
      cfg_r.matrix_scan_ms   <= MATRIX_SCAN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DIRECT_DEBOUNCE: cfg_r.btn_settle_ms    <= cfg_wdata[7:0];
        CFG_MATRIX_DEBOUNCE: cfg_r.key_settle_ms    <= cfg_wdata[7:0];
        CFG_LONG_PRESS:      cfg_r.long_press_ms    <= cfg_wdata[15:0];
        CFG_ARM_RELEASE:     cfg_r.arm_release_ms   <= cfg_wdata[9:0];
        CFG_STARTUP_QUIET:   cfg_r.startup_quiet_ms <= cfg_wdata[9:0];
        CFG_BUTTON_POLL:     cfg_r.button_poll_ms   <= cfg_wdata[7:0];
        CFG_MATRIX_SCAN:     cfg_r.matrix_scan_ms   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !st_r.started) |=> (out_data == '0))
    else $error("first poll result not all zero");

  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("evaluated request did not reach the result register");

  a_enc_events: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_data.enc_press, out_data.enc_short, out_data.enc_long}))
    else $error("conflicting encoder button events");

  a_key_route: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.step_key == '0 || out_data.shift_step_key == '0))
    else $error("step key reported on both routes");

  a_shift_route: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.shift_step_key != '0 || out_data.shift_play_event ||
                   out_data.shift_rec_event)) |-> out_data.shift_level)
    else $error("shifted event without shift level");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.encoder_steps != -8'sd128))
    else $error("encoder steps outside clamp");

endmodule

`default_nettype wire

### src/fpiq_eval.sv
// Single-pass evaluation of one poll request against the panel state.
// Produces the next state and the result fields. Depends on fpiq_pkg.
`default_nettype none

module fpiq_eval
  import fpiq_pkg::*;
(
  input  wire in_t  item,
  input  wire st_t  st,
  input  wire cfg_t cfg,
  output st_t       st_nxt,
  output out_t      res
);

  logic [31:0]          now;
  logic [2:0]           btn;
  logic [STEP_KEYS-1:0] keys;
  logic                 lvl;
  logic [15:0]          diff;
  logic signed [15:0]   sdiff;
  logic signed [7:0]    step8;
  logic                 poll_due;
  logic                 scan_due;
  logic                 quiet;
  logic                 was_shift;
  logic                 now_shift;
  logic [2:0]           falling;
  logic [STEP_KEYS-1:0] rising;
  logic [KEY_NUM_W-1:0] key_num;

  assign now  = item.now_ms;
  assign btn  = ~item.panel_buttons_n;
  assign keys = item.key_matrix;
  assign lvl  = item.enc_button_level;
  assign diff = item.enc_count - st.last_count;
  assign sdiff = signed'(diff);
  assign rising = st.key_candidate & ~st.key_stable;

  always_comb begin
    if (sdiff > STEP_CLAMP) begin
      step8 = 8'sd127;
    end else if (sdiff < -STEP_CLAMP) begin
      step8 = -8'sd127;
    end else begin
      step8 = sdiff[7:0];
    end
  end

  always_comb begin
    key_num = '0;
    for (int i = 0; i < STEP_KEYS; i++) begin
      if (rising[i]) key_num = KEY_NUM_W'(i + 1);
    end
  end

  assign poll_due = (now - st.last_button_poll) >= {24'd0, cfg.button_poll_ms};
  assign scan_due = (now - st.last_key_scan) >= {24'd0, cfg.matrix_scan_ms};
  assign quiet    = (now - st.quiet_until) >> 31 != 32'd0;

  always_comb begin
    st_nxt    = st;
    res       = '0;
    was_shift = st.button_stable_prev[2];
    now_shift = 1'b0;
    falling   = '0;

    if (!st.started) begin
      st_nxt.started               = 1'b1;
      st_nxt.last_count            = item.enc_count;
      st_nxt.enc_prev_level        = lvl;
      st_nxt.enc_is_down           = 1'b0;
      st_nxt.long_fired            = 1'b0;
      st_nxt.enc_down_time         = now;
      st_nxt.quiet_until           = now + {22'd0, cfg.startup_quiet_ms};
      st_nxt.button_candidate      = btn;
      st_nxt.button_stable         = btn;
      st_nxt.button_stable_prev    = btn;
      st_nxt.button_candidate_time = now;
      st_nxt.last_button_poll      = now;
      st_nxt.last_key_scan         = now;
      st_nxt.key_candidate         = '0;
      st_nxt.key_stable            = '0;
      st_nxt.key_candidate_time    = now;
      st_nxt.armed                 = 1'b0;
      st_nxt.released_since        = now;
      st_nxt.shift_down            = 1'b0;
      st_nxt.shift_used            = 1'b0;
    end else begin
      if (diff != 16'd0) begin
        res.encoder_steps = step8;
        st_nxt.last_count = st.last_count + {{8{step8[7]}}, step8};
        if (st.shift_down) st_nxt.shift_used = 1'b1;
      end

      if (st.enc_prev_level && !lvl) begin
        res.enc_press        = 1'b1;
        st_nxt.enc_is_down   = 1'b1;
        st_nxt.long_fired    = 1'b0;
        st_nxt.enc_down_time = now;
        if (st.shift_down) st_nxt.shift_used = 1'b1;
      end else if (!st.enc_prev_level && !lvl) begin
        if (st.enc_is_down && !st.long_fired &&
            (now - st.enc_down_time) >= {16'd0, cfg.long_press_ms}) begin
          res.enc_long      = 1'b1;
          st_nxt.long_fired = 1'b1;
        end
      end else if (!st.enc_prev_level && lvl) begin
        if (st.enc_is_down && !st.long_fired) res.enc_short = 1'b1;
        st_nxt.enc_is_down = 1'b0;
        st_nxt.long_fired  = 1'b0;
      end
      st_nxt.enc_prev_level = lvl;

      if (poll_due) begin
        st_nxt.last_button_poll = now;
        if (btn != st.button_candidate) begin
          st_nxt.button_candidate      = btn;
          st_nxt.button_candidate_time = now;
        end else if ((now - st.button_candidate_time) >= {24'd0, cfg.btn_settle_ms}) begin
          st_nxt.button_stable = st.button_candidate;
        end
        falling   = st_nxt.button_stable & ~st.button_stable_prev;
        now_shift = st_nxt.button_stable[2];
        if (!was_shift && now_shift) st_nxt.shift_used = 1'b0;
        if (was_shift && !now_shift && !st_nxt.shift_used) res.shift_tap = 1'b1;
        st_nxt.button_stable_prev = st_nxt.button_stable;
        if (!st.armed) begin
          if (st_nxt.button_stable == 3'd0) begin
            if ((now - st.released_since) >= {22'd0, cfg.arm_release_ms}) begin
              st_nxt.armed = 1'b1;
            end
          end else begin
            st_nxt.released_since = now;
          end
        end
        st_nxt.shift_down = now_shift;
        if (st_nxt.armed && !quiet && falling[0]) begin
          if (now_shift) begin
            res.shift_play_event = 1'b1;
            st_nxt.shift_used    = 1'b1;
          end else begin
            res.play_event = 1'b1;
          end
        end
        if (st_nxt.armed && !quiet && falling[1]) begin
          if (now_shift) begin
            res.shift_rec_event = 1'b1;
            st_nxt.shift_used   = 1'b1;
          end else begin
            res.rec_event = 1'b1;
          end
        end

        if (scan_due) begin
          st_nxt.last_key_scan = now;
          if (keys != st.key_candidate) begin
            st_nxt.key_candidate      = keys;
            st_nxt.key_candidate_time = now;
          end else if ((now - st.key_candidate_time) >= {24'd0, cfg.key_settle_ms}) begin
            st_nxt.key_stable = st.key_candidate;
            if (st_nxt.armed && !quiet && rising != '0) begin
              if (now_shift) begin
                res.shift_step_key = key_num;
                st_nxt.shift_used  = 1'b1;
              end else begin
                res.step_key = key_num;
              end
            end
          end
        end
      end
      res.shift_level = st_nxt.shift_down;
    end
  end

endmodule

`default_nettype wire

### tb/front_panel_input_qualifier_tb.sv
// Self-checking bench for front_panel_input_qualifier: drives panel polls, checks every result.
// A scoreboard class predicts each result from its own copy of the panel state and settings.
// Depends on fpiq_pkg and the front_panel_input_qualifier RTL.
`default_nettype none

module front_panel_input_qualifier_tb;
  import fpiq_pkg::*;

  localparam int RESET_CYCLES    = 8;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int DRAIN_CYCLES    = 4;
  localparam int STUCK_LIMIT     = 1000;
  localparam int MAX_SHOWN       = 10;

  localparam int PLAY_BIT  = 0;
  localparam int REC_BIT   = 1;
  localparam int SHIFT_BIT = 2;

  localparam logic [2:0]           BTN_ALL_UP    = 3'b111;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = '1;
  localparam logic [31:0]          START_MS      = 32'hFFFF_FF80;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  class panel_scoreboard;
    cfg_t           cfg;
    out_t           expected_results[$];
    int             errors;
    bit             started;
    bit [15:0]      last_count;
    bit             enc_prev_level;
    bit             enc_is_down;
    bit             long_fired;
    bit [31:0]      enc_down_time;
    bit [31:0]      last_button_poll;
    bit [31:0]      last_key_scan;
    bit [31:0]      quiet_until;
    bit [2:0]       btn_cand;
    bit [31:0]      btn_cand_time;
    bit [2:0]       btn_stable;
    bit [2:0]       btn_prev;
    bit             armed;
    bit [31:0]      released_since;
    bit             shift_down;
    bit             shift_used;
    bit [STEP_KEYS-1:0] key_cand;
    bit [31:0]      key_cand_time;
    bit [STEP_KEYS-1:0] key_stable;

    function new();
      cfg.btn_settle_ms    = DIRECT_DEBOUNCE_RST;
      cfg.key_settle_ms    = MATRIX_DEBOUNCE_RST;
      cfg.long_press_ms    = LONG_PRESS_RST;
      cfg.arm_release_ms   = ARM_RELEASE_RST;
      cfg.startup_quiet_ms = STARTUP_QUIET_RST;
      cfg.button_poll_ms   = BUTTON_POLL_RST;
      cfg.matrix_scan_ms   = MATRIX_SCAN_RST;
      enc_prev_level = 1'b1;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DIRECT_DEBOUNCE: cfg.btn_settle_ms    = val[7:0];
        CFG_MATRIX_DEBOUNCE: cfg.key_settle_ms    = val[7:0];
        CFG_LONG_PRESS:      cfg.long_press_ms    = val[15:0];
        CFG_ARM_RELEASE:     cfg.arm_release_ms   = val[9:0];
        CFG_STARTUP_QUIET:   cfg.startup_quiet_ms = val[9:0];
        CFG_BUTTON_POLL:     cfg.button_poll_ms   = val[7:0];
        CFG_MATRIX_SCAN:     cfg.matrix_scan_ms   = val[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function logic [31:0] since(logic [31:0] stamp, logic [31:0] now_ms);
      return now_ms - stamp;
    endfunction

    function void qualify_poll(in_t p);
      out_t                 r;
      logic [31:0]          now_ms;
      logic [2:0]           btn;
      logic [2:0]           falling;
      logic [STEP_KEYS-1:0] rising;
      logic [15:0]          diff;
      logic signed [15:0]   delta;
      logic [31:0]          quiet_gap;
      logic [KEY_NUM_W-1:0] key_num;
      logic                 quiet;
      logic                 was_shift;
      logic                 now_shift;
      r = '0;
      now_ms = p.now_ms;
      btn = ~p.panel_buttons_n;
      if (!started) begin
        started = 1'b1;
        last_count = p.enc_count;
        enc_prev_level = p.enc_button_level;
        enc_is_down = 1'b0;
        long_fired = 1'b0;
        enc_down_time = now_ms;
        quiet_until = now_ms + cfg.startup_quiet_ms;
        btn_cand = btn;
        btn_stable = btn;
        btn_prev = btn;
        btn_cand_time = now_ms;
        last_button_poll = now_ms;
        last_key_scan = now_ms;
        key_cand = '0;
        key_stable = '0;
        key_cand_time = now_ms;
        armed = 1'b0;
        released_since = now_ms;
        shift_down = 1'b0;
        shift_used = 1'b0;
        expected_results.push_back(r);
        return;
      end

      diff = p.enc_count - last_count;
      delta = diff;
      if (delta != 0) begin
        if (delta > STEP_CLAMP) delta = STEP_CLAMP;
        else if (delta < -STEP_CLAMP) delta = -STEP_CLAMP;
        r.encoder_steps = delta[7:0];
        last_count = last_count + delta;
        if (shift_down) shift_used = 1'b1;
      end

      if (enc_prev_level && !p.enc_button_level) begin
        r.enc_press = 1'b1;
        enc_is_down = 1'b1;
        long_fired = 1'b0;
        enc_down_time = now_ms;
        if (shift_down) shift_used = 1'b1;
      end else if (!enc_prev_level && !p.enc_button_level) begin
        if (enc_is_down && !long_fired &&
            since(enc_down_time, now_ms) >= cfg.long_press_ms) begin
          r.enc_long = 1'b1;
          long_fired = 1'b1;
        end
      end else if (!enc_prev_level && p.enc_button_level) begin
        if (enc_is_down && !long_fired) r.enc_short = 1'b1;
        enc_is_down = 1'b0;
        long_fired = 1'b0;
      end
      enc_prev_level = p.enc_button_level;

      if (since(last_button_poll, now_ms) >= cfg.button_poll_ms) begin
        last_button_poll = now_ms;
        if (btn != btn_cand) begin
          btn_cand = btn;
          btn_cand_time = now_ms;
        end else if (since(btn_cand_time, now_ms) >= cfg.btn_settle_ms) begin
          btn_stable = btn_cand;
        end
        falling = btn_stable & ~btn_prev;
        was_shift = btn_prev[SHIFT_BIT];
        now_shift = btn_stable[SHIFT_BIT];
        quiet_gap = now_ms - quiet_until;
        quiet = quiet_gap[31];
        if (!was_shift && now_shift) shift_used = 1'b0;
        if (was_shift && !now_shift && !shift_used) r.shift_tap = 1'b1;
        btn_prev = btn_stable;
        if (!armed) begin
          if (btn_stable == '0) begin
            if (since(released_since, now_ms) >= cfg.arm_release_ms) armed = 1'b1;
          end else begin
            released_since = now_ms;
          end
        end
        shift_down = now_shift;
        if (armed && !quiet && falling[PLAY_BIT]) begin
          if (now_shift) begin
            r.shift_play_event = 1'b1;
            shift_used = 1'b1;
          end else begin
            r.play_event = 1'b1;
          end
        end
        if (armed && !quiet && falling[REC_BIT]) begin
          if (now_shift) begin
            r.shift_rec_event = 1'b1;
            shift_used = 1'b1;
          end else begin
            r.rec_event = 1'b1;
          end
        end

        if (since(last_key_scan, now_ms) >= cfg.matrix_scan_ms) begin
          last_key_scan = now_ms;
          if (p.key_matrix != key_cand) begin
            key_cand = p.key_matrix;
            key_cand_time = now_ms;
          end else if (since(key_cand_time, now_ms) >= cfg.key_settle_ms) begin
            rising = key_cand & ~key_stable;
            key_stable = key_cand;
            if (armed && !quiet && rising != '0) begin
              key_num = '0;
              for (int i = 0; i < STEP_KEYS; i++) if (rising[i]) key_num = KEY_NUM_W'(i + 1);
              if (now_shift) begin
                r.shift_step_key = key_num;
                shift_used = 1'b1;
              end else begin
                r.step_key = key_num;
              end
            end
          end
        end
      end
      r.shift_level = shift_down;
      expected_results.push_back(r);
    endfunction

    function string fmt_result(out_t r);
      return $sformatf({"steps=%0d press=%0b short=%0b long=%0b play=%0b splay=%0b ",
                        "rec=%0b srec=%0b tap=%0b key=%0d skey=%0d shift=%0b"},
                       r.encoder_steps, r.enc_press, r.enc_short, r.enc_long,
                       r.play_event, r.shift_play_event, r.rec_event, r.shift_rec_event,
                       r.shift_tap, r.step_key, r.shift_step_key, r.shift_level);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= MAX_SHOWN) $display("ERROR: %s", msg);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        note_error({"result with no poll pending: ", fmt_result(got)});
        return;
      end
      want = expected_results.pop_front();
      if (got !== want)
        note_error({"result mismatch\n  expected ", fmt_result(want),
                    "\n  actual   ", fmt_result(got)});
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  panel_scoreboard       board;
  idle_mode_t            idle_mode = IDLE_NONE;
  int                    stuck_cycles = 0;

  logic [31:0]           panel_now = START_MS;
  logic [15:0]           enc_pos = '0;
  logic                  enc_level = 1'b1;
  logic [2:0]            buttons_n = BTN_ALL_UP;
  logic [STEP_KEYS-1:0]  keys_down = '0;
  logic [31:0]           btn_change_at;
  logic [31:0]           key_change_at;
  logic [31:0]           lvl_change_at;

  front_panel_input_qualifier u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int idle_pct(bit receiver);
    case (idle_mode)
      IDLE_SENDER:   return receiver ? 0 : 49;
      IDLE_RECEIVER: return receiver ? 49 : 0;
      IDLE_BOTH:     return 10;
      default:       return 0;
    endcase
  endfunction

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));

  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles <= 0;
    end else begin
      if (out_valid && out_ready) board.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit due(logic [31:0] at);
    logic [31:0] gap;
    gap = panel_now - at;
    return !gap[31];
  endfunction

  function automatic logic [31:0] hold_ms(int unsigned deb);
    if ($urandom_range(0, 99) < 15) return $urandom_range(0, deb / 2);
    return $urandom_range(deb, 3 * deb + 40);
  endfunction

  function automatic in_t current_poll();
    in_t p;
    p.now_ms           = panel_now;
    p.enc_count        = enc_pos;
    p.enc_button_level = enc_level;
    p.panel_buttons_n  = buttons_n;
    p.key_matrix       = keys_down;
    return p;
  endfunction

  function automatic in_t random_poll();
    int unsigned pick;
    int unsigned span;
    int unsigned long_ms;
    pick = $urandom_range(0, 99);
    span = board.cfg.button_poll_ms / 2 + 6;
    if (pick < 2) begin
      panel_now += $urandom();
      btn_change_at = panel_now;
      key_change_at = panel_now;
      lvl_change_at = panel_now;
    end else if (pick < 8) begin
      panel_now += $urandom_range(0, 2000);
    end else begin
      panel_now += $urandom_range(0, span);
    end

    pick = $urandom_range(0, 99);
    if (pick < 5) enc_pos = 16'($urandom());
    else if (pick < 40) enc_pos = enc_pos + 16'($urandom_range(0, 8)) - 16'd4;

    if (due(btn_change_at)) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) buttons_n ^= 3'b001 << $urandom_range(0, 2);
      else if (pick < 80) buttons_n = BTN_ALL_UP;
      else buttons_n = 3'($urandom());
      btn_change_at = panel_now
                    + hold_ms(board.cfg.btn_settle_ms + board.cfg.button_poll_ms);
    end

    if (due(key_change_at)) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) keys_down ^= STEP_KEYS'(1) << $urandom_range(0, STEP_KEYS - 1);
      else if (pick < 70) keys_down = '0;
      else if (pick < 85) keys_down |= STEP_KEYS'($urandom()) & STEP_KEYS'($urandom());
      else keys_down = STEP_KEYS'($urandom());
      key_change_at = panel_now + hold_ms(board.cfg.key_settle_ms
                                          + board.cfg.matrix_scan_ms
                                          + board.cfg.button_poll_ms);
    end

    if (due(lvl_change_at)) begin
      enc_level = ~enc_level;
      long_ms = board.cfg.long_press_ms;
      if (!enc_level)
        lvl_change_at = panel_now + ($urandom_range(0, 1) ? $urandom_range(0, long_ms / 2)
                                                          : long_ms + $urandom_range(0, 200));
      else
        lvl_change_at = panel_now + $urandom_range(0, 150);
    end
    return current_poll();
  endfunction

  task automatic send_poll(in_t p);
    while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    board.qualify_poll(p);
  endtask

  task automatic send_directed(logic [31:0] dt, logic [15:0] cnt, logic lvl,
                               logic [2:0] btn_n, logic [STEP_KEYS-1:0] keys);
    panel_now += dt;
    enc_pos   = cnt;
    enc_level = lvl;
    buttons_n = btn_n;
    keys_down = keys;
    send_poll(current_poll());
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic apply_settings(int phase);
    cfg_t                  c;
    logic [CFG_DATA_W-1:0] fill;
    fill = '0;
    case (phase)
      1: c = '0;
      2: begin
        c = '1;
        fill = '1;
      end
      default: begin
        c.btn_settle_ms    = 8'($urandom_range(0, 40));
        c.key_settle_ms    = 8'($urandom_range(0, 40));
        c.long_press_ms    = 16'($urandom_range(0, 800));
        c.arm_release_ms   = 10'($urandom_range(0, 1023));
        c.startup_quiet_ms = 10'($urandom_range(0, 1023));
        c.button_poll_ms   = 8'($urandom_range(0, 12));
        c.matrix_scan_ms   = 8'($urandom_range(0, 25));
      end
    endcase
    write_reg(CFG_DIRECT_DEBOUNCE, fill | CFG_DATA_W'(c.btn_settle_ms));
    write_reg(CFG_MATRIX_DEBOUNCE, fill | CFG_DATA_W'(c.key_settle_ms));
    write_reg(CFG_LONG_PRESS,      fill | CFG_DATA_W'(c.long_press_ms));
    write_reg(CFG_ARM_RELEASE,     fill | CFG_DATA_W'(c.arm_release_ms));
    write_reg(CFG_STARTUP_QUIET,   fill | CFG_DATA_W'(c.startup_quiet_ms));
    write_reg(CFG_BUTTON_POLL,     fill | CFG_DATA_W'(c.button_poll_ms));
    write_reg(CFG_MATRIX_SCAN,     fill | CFG_DATA_W'(c.matrix_scan_ms));
    write_reg(CFG_IDX_SPARE,       CFG_DATA_W'($urandom()));
    cfg_we <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    send_directed(32'd0,   16'h0000, 1'b1, 3'b111, 12'h000);
    send_directed(32'd30,  16'h7FFF, 1'b1, 3'b111, 12'h000);
    send_directed(32'd50,  16'h7FFF, 1'b1, 3'b111, 12'h000);
    send_directed(32'd2,   16'h7FFF, 1'b1, 3'b111, 12'h000);
    send_directed(32'd60,  16'hFFFF, 1'b0, 3'b110, 12'h000);
    send_directed(32'd20,  16'hFFFF, 1'b0, 3'b110, 12'hFFF);
    send_directed(32'd20,  16'hFFFF, 1'b0, 3'b110, 12'hFFF);
    send_directed(32'd400, 16'hFFFF, 1'b0, 3'b111, 12'h000);
    send_directed(32'd5,   16'h8000, 1'b1, 3'b011, 12'h000);
    send_directed(32'd20,  16'h8000, 1'b1, 3'b011, 12'h000);
    send_directed(32'd20,  16'h8000, 1'b1, 3'b000, 12'h000);
    send_directed(32'd20,  16'h8000, 1'b1, 3'b000, 12'h00C);
    send_directed(32'd20,  16'h8001, 1'b1, 3'b011, 12'h00C);
    send_directed(32'd20,  16'h8001, 1'b1, 3'b111, 12'h000);
    send_directed(32'd20,  16'h8001, 1'b1, 3'b011, 12'h000);
    send_directed(32'd20,  16'h8001, 1'b1, 3'b011, 12'h000);
    send_directed(32'd20,  16'h8001, 1'b1, 3'b111, 12'h000);
    send_directed(32'd20,  16'h8001, 1'b1, 3'b111, 12'h000);
    send_directed(32'd5,   16'h8001, 1'b0, 3'b111, 12'h000);
    send_directed(32'd5,   16'h8001, 1'b1, 3'b111, 12'h000);
    send_directed(32'h8000_0010, 16'h8001, 1'b1, 3'b110, 12'h000);
    send_directed(32'd20,  16'h8001, 1'b1, 3'b110, 12'h801);
    send_directed(32'd20,  16'h8001, 1'b1, 3'b110, 12'h801);
    send_directed(32'h8000_0000, 16'h8001, 1'b1, 3'b101, 12'h7F0);
    send_directed(32'd20,  16'h8001, 1'b1, 3'b101, 12'h7F0);
  endtask

  initial begin
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    btn_change_at = panel_now;
    key_change_at = panel_now;
    lvl_change_at = panel_now;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        drain_results();
        apply_settings(phase);
      end
      idle_mode = idle_mode_t'(phase % 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 199) == 0) drain_results();
        send_poll(random_poll());
      end
    end
    drain_results();
    if (board.errors == 0 && board.pending() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
src/fpiq_pkg.sv
src/fpiq_eval.sv
src/front_panel_input_qualifier.sv
tb/front_panel_input_qualifier_tb.sv
